// ===== rtl/ddmix_pkg.sv =====
// Shared types and constants of the differential-drive mixer.
package ddmix_pkg;

  localparam int SPEED_W  = 8;
  localparam int VEC_W    = 10;
  localparam int CHK_W    = 11;
  localparam int DUTY_W   = 8;
  localparam int TICK_W   = 16;
  localparam int OFFS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W    = 12;  // checksum arithmetic, wide enough for every operand
  localparam int SEGX_W   = 6;   // offset into one 45-degree segment

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd4000;
  localparam logic [OFFS_W-1:0] OFFSET_RESET  = 8'd100;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  localparam logic signed [VEC_W-1:0] FULL_SCALE = 10'sd255;
  localparam logic signed [VEC_W-1:0] HEAD_LIMIT = 10'sd180;
  localparam logic signed [VEC_W-1:0] SEG1       = 10'sd45;
  localparam logic signed [VEC_W-1:0] SEG2       = 10'sd90;
  localparam logic signed [VEC_W-1:0] SEG3       = 10'sd135;

  // 1/3 as 683/2048, exact for the ramp products (at most 765).
  localparam logic [9:0] THIRD_RECIP = 10'd683;

  typedef enum logic [1:0] {
    ST_TICK   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT = 2'd0,
    REG_OFFSET  = 2'd1
  } cfg_reg_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mix;
    logic scale;
    logic commit;
  } ddmix_cmd_t;

endpackage

// ===== rtl/ddmix_ifs.sv =====
// Channel interfaces of the mixer: input items, result items and register writes.
interface ddmix_in_if import ddmix_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [SPEED_W-1:0]        speed;
  logic signed [VEC_W-1:0]   vector;
  logic signed [CHK_W-1:0]   check_value;

  modport source (output valid, command, speed, vector, check_value, input ready);
  modport sink   (input valid, command, speed, vector, check_value, output ready);
endinterface

interface ddmix_out_if import ddmix_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  left_duty;
  logic               left_forward;
  logic [DUTY_W-1:0]  right_duty;
  logic               right_forward;
  logic [1:0]         status;
  logic               failsafe_active;

  modport source (output valid, left_duty, left_forward, right_duty, right_forward, status,
                  failsafe_active, input ready);
  modport sink   (input valid, left_duty, left_forward, right_duty, right_forward, status,
                  failsafe_active, output ready);
endinterface

interface ddmix_cfg_if import ddmix_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ddmix_ctrl.sv =====
// Controller of the mixer: sequences one item through mix, scale and commit.
module ddmix_ctrl import ddmix_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output ddmix_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_SCALE,
    S_COMMIT
  } state_t;

  state_t state;
  logic   can_commit;

  assign in_ready   = (state == S_IDLE);
  // The result register is free once its beat has gone or goes in this cycle.
  assign can_commit = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.mix    = (state == S_MIX);
    cmd.scale  = (state == S_SCALE);
    cmd.commit = (state == S_COMMIT) && can_commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MIX;
        end
        S_MIX:    state <= S_SCALE;
        S_SCALE:  state <= S_COMMIT;
        S_COMMIT: begin
          if (can_commit) state <= S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ddmix_dp.sv =====
// Datapath of the mixer: checksum gate, heading mix, speed scaling and drive state.
module ddmix_dp import ddmix_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  ddmix_cmd_t              cmd,
  input  logic                    command,
  input  logic [SPEED_W-1:0]      speed,
  input  logic signed [VEC_W-1:0] vector,
  input  logic signed [CHK_W-1:0] check_value,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic [DUTY_W-1:0]       left_duty,
  output logic                    left_forward,
  output logic [DUTY_W-1:0]       right_duty,
  output logic                    right_forward,
  output logic [1:0]              status,
  output logic                    failsafe_active
);

  // Configuration registers.
  logic [TICK_W-1:0] timeout_ticks;
  logic [OFFS_W-1:0] checksum_offset;

  // Captured item.
  logic                    is_tick;
  logic [SPEED_W-1:0]      spd;
  logic signed [VEC_W-1:0] vec;
  logic signed [CHK_W-1:0] chk;

  // Mix stage results.
  logic              chk_ok;
  logic [DUTY_W-1:0] mag_l, mag_r;
  logic              pos_l, pos_r;

  // Scale stage results.
  logic [2*DUTY_W-1:0] prod_l, prod_r;

  // Drive state.
  logic [TICK_W-1:0] elapsed_ticks;

  // Checksum compare at full precision.
  logic signed [SUM_W-1:0] expect_sum, chk_ext;

  // Heading mix.
  logic signed [VEC_W-1:0] seg_base, xw, ramp_s, wl, wr, neg_l, neg_r;
  logic [SEGX_W-1:0]       x;
  logic [9:0]              p17;
  logic [19:0]             pr;
  logic [DUTY_W-1:0]       ramp;

  // Commit.
  logic [DUTY_W-1:0] q_l, q_r;
  logic [TICK_W-1:0] elapsed_inc, elapsed_next;
  logic              tick_clear;

  function automatic logic [DUTY_W-1:0] div255(input logic [2*DUTY_W-1:0] p);
    logic [2*DUTY_W:0] s;
    logic [DUTY_W:0]   q;
    s = {1'b0, p} + {{(DUTY_W+1){1'b0}}, p[2*DUTY_W-1:DUTY_W]} + {{(2*DUTY_W){1'b0}}, 1'b1};
    q = s[2*DUTY_W:DUTY_W];
    return q[DUTY_W] ? {DUTY_W{1'b1}} : q[DUTY_W-1:0];
  endfunction

  assign expect_sum = SUM_W'(vec) + $signed({{(SUM_W-SPEED_W){1'b0}}, spd})
                    - $signed({{(SUM_W-OFFS_W){1'b0}}, checksum_offset});
  assign chk_ext    = SUM_W'(chk);

  // Segment base: the offset into the segment drives the one ramp in use.
  always_comb begin
    if (vec > SEG3)             seg_base = -SEG3;
    else if (vec > SEG2)        seg_base = -SEG2;
    else if (vec > SEG1)        seg_base = -SEG1;
    else if (vec > 10'sd0)      seg_base = 10'sd0;
    else if (vec > -SEG1)       seg_base = SEG1;
    else if (vec > -SEG2)       seg_base = SEG2;
    else if (vec > -SEG3)       seg_base = SEG3;
    else                        seg_base = HEAD_LIMIT;
  end

  assign xw     = vec + seg_base;
  assign x      = xw[SEGX_W-1:0];
  assign p17    = {x, 4'b0000} + {4'b0000, x};
  assign pr     = p17 * THIRD_RECIP;
  assign ramp   = pr[18:11];
  assign ramp_s = $signed({{(VEC_W-DUTY_W){1'b0}}, ramp});

  always_comb begin
    if (vec > HEAD_LIMIT || vec < -HEAD_LIMIT) begin
      wl = 10'sd0;                 wr = 10'sd0;
    end else if (vec > SEG3) begin
      wl = -FULL_SCALE;            wr = ramp_s;
    end else if (vec > SEG2) begin
      wl = -FULL_SCALE;            wr = ramp_s - FULL_SCALE;
    end else if (vec > SEG1) begin
      wl = -ramp_s;                wr = -FULL_SCALE;
    end else if (vec > 10'sd0) begin
      wl = FULL_SCALE - ramp_s;    wr = -FULL_SCALE;
    end else if (vec > -SEG1) begin
      wl = FULL_SCALE;             wr = -ramp_s;
    end else if (vec > -SEG2) begin
      wl = FULL_SCALE;             wr = FULL_SCALE - ramp_s;
    end else if (vec > -SEG3) begin
      wl = ramp_s;                 wr = FULL_SCALE;
    end else begin
      wl = ramp_s - FULL_SCALE;    wr = FULL_SCALE;
    end
  end

  assign neg_l = -wl;
  assign neg_r = -wr;

  assign q_l = div255(prod_l);
  assign q_r = div255(prod_r);

  assign elapsed_inc = (elapsed_ticks != TICK_MAX) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign tick_clear  = is_tick && (elapsed_inc > timeout_ticks);

  always_comb begin
    if (is_tick)     elapsed_next = elapsed_inc;
    else if (chk_ok) elapsed_next = '0;
    else             elapsed_next = elapsed_ticks;
  end

  // Configuration and drive state.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= TIMEOUT_RESET;
      checksum_offset <= OFFSET_RESET;
      elapsed_ticks   <= '0;
      left_duty       <= '0;
      left_forward    <= 1'b0;
      right_duty      <= '0;
      right_forward   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_ticks   <= cfg_data;
          REG_OFFSET:  checksum_offset <= cfg_data[OFFS_W-1:0];
          default:     ;
        endcase
      end
      if (cmd.commit) begin
        elapsed_ticks <= elapsed_next;
        if (tick_clear) begin
          left_duty     <= '0;
          left_forward  <= 1'b0;
          right_duty    <= '0;
          right_forward <= 1'b0;
        end else if (!is_tick && chk_ok) begin
          left_duty     <= q_l;
          left_forward  <= pos_l && (q_l != '0);
          right_duty    <= q_r;
          right_forward <= pos_r && (q_r != '0);
        end
      end
    end
  end

  // Item capture and stage registers carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_tick <= command;
      spd     <= speed;
      vec     <= vector;
      chk     <= check_value;
    end
    if (cmd.mix) begin
      chk_ok <= (chk_ext == expect_sum);
      mag_l  <= wl[VEC_W-1] ? neg_l[DUTY_W-1:0] : wl[DUTY_W-1:0];
      mag_r  <= wr[VEC_W-1] ? neg_r[DUTY_W-1:0] : wr[DUTY_W-1:0];
      pos_l  <= (wl > 10'sd0);
      pos_r  <= (wr > 10'sd0);
    end
    if (cmd.scale) begin
      prod_l <= mag_l * spd;
      prod_r <= mag_r * spd;
    end
    if (cmd.commit) begin
      if (is_tick)     status <= ST_TICK;
      else if (chk_ok) status <= ST_ACCEPT;
      else             status <= ST_REJECT;
      failsafe_active <= (elapsed_next > timeout_ticks);
    end
  end

endmodule

// ===== rtl/diff_drive_mixer_with_failsafe_unit.sv =====
// Top level of the differential-drive mixer with command-loss failsafe.
//
//   channel  | role | beat contents
//   ---------+------+---------------------------------------------------------
//   in_ch    | sink | command, speed, vector, check_value
//   out_ch   | src  | left/right duty and forward flags, status, failsafe_active
//   cfg_ch   | sink | index (0 timeout_ticks, 1 checksum_offset), data
//
// Each input beat passes through four steps: capture, mix (the ramp multiply), scale (the
// two speed multipliers) and commit into the drive state and result register.
// A stalled result beat holds the commit back; the next input beat is taken as
// soon as the commit is done, while that result still waits.
// Reset is synchronous: it restores both registers to 4000 and 100, clears the
// drive state and the tick count, and empties the result register.
module diff_drive_mixer_with_failsafe_unit import ddmix_pkg::*; (
  input logic      clk,
  input logic      rst,
  ddmix_in_if.sink   in_ch,
  ddmix_out_if.source out_ch,
  ddmix_cfg_if.sink  cfg_ch
);

  ddmix_cmd_t cmd;
  logic [1:0] status;

  assign cfg_ch.ready  = 1'b1;
  assign out_ch.status = status;

  ddmix_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ddmix_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .command         (in_ch.command),
    .speed           (in_ch.speed),
    .vector          (in_ch.vector),
    .check_value     (in_ch.check_value),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .left_duty       (out_ch.left_duty),
    .left_forward    (out_ch.left_forward),
    .right_duty      (out_ch.right_duty),
    .right_forward   (out_ch.right_forward),
    .status          (status),
    .failsafe_active (out_ch.failsafe_active)
  );

endmodule

// ===== rtl/ddmix_chk.sv =====
// Port-level checks of the mixer and their binding to the top level.
module ddmix_chk import ddmix_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] left_duty,
  input logic              left_forward,
  input logic [DUTY_W-1:0] right_duty,
  input logic              right_forward,
  input logic [1:0]        status,
  input logic              failsafe_active
);

  // A result beat waits, unchanged, until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_duty) && $stable(right_duty)
      && $stable(status) && $stable(failsafe_active))
    else $error("result beat changed while stalled");

  // One item is worked on at a time: after a beat is taken the input is busy.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in flight");

  // An accepted command restarts the timer, so the failsafe cannot show with it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ACCEPT |-> !failsafe_active)
    else $error("failsafe reported with an accepted command");

  // A stopped wheel never reports forward.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_duty != '0 || !left_forward) && (right_duty != '0 || !right_forward))
    else $error("forward flag set with zero duty");

  // A command taken while no result waits cannot give a result before it is worked through.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared before the item was worked through");

endmodule

bind diff_drive_mixer_with_failsafe_unit ddmix_chk u_ddmix_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .left_duty       (out_ch.left_duty),
  .left_forward    (out_ch.left_forward),
  .right_duty      (out_ch.right_duty),
  .right_forward   (out_ch.right_forward),
  .status          (out_ch.status),
  .failsafe_active (out_ch.failsafe_active)
);
